### rtl/c8ie_pkg.sv
package c8ie_pkg;

    localparam int MEM_DEPTH      = 4096;
    localparam int STACK_DEPTH    = 16;
    localparam int DISPLAY_PIXELS = 2048;
    localparam int FONT_BASE      = 80;
    localparam int KEY_COUNT      = 16;

    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int SP_W       = $clog2(STACK_DEPTH);
    localparam int DISP_BYTES = DISPLAY_PIXELS / 8;
    localparam int DISP_AW    = $clog2(DISP_BYTES);
    localparam int KEY_W      = $clog2(KEY_COUNT);

    // item operations
    typedef enum logic [2:0] {
        OP_EXEC    = 3'd0,
        OP_MEM_WR  = 3'd1,
        OP_MEM_RD  = 3'd2,
        OP_DISP_RD = 3'd3,
        OP_TICK    = 3'd4
    } t_op;

    // instruction groups (top nibble)
    localparam logic [3:0] OPC_SYS  = 4'h0;
    localparam logic [3:0] OPC_JP   = 4'h1;
    localparam logic [3:0] OPC_CALL = 4'h2;
    localparam logic [3:0] OPC_SEI  = 4'h3;
    localparam logic [3:0] OPC_SNEI = 4'h4;
    localparam logic [3:0] OPC_SE   = 4'h5;
    localparam logic [3:0] OPC_LDI  = 4'h6;
    localparam logic [3:0] OPC_ADDI = 4'h7;
    localparam logic [3:0] OPC_ALU  = 4'h8;
    localparam logic [3:0] OPC_SNE  = 4'h9;
    localparam logic [3:0] OPC_LDIX = 4'hA;
    localparam logic [3:0] OPC_JPV0 = 4'hB;
    localparam logic [3:0] OPC_RND  = 4'hC;
    localparam logic [3:0] OPC_DRW  = 4'hD;
    localparam logic [3:0] OPC_KEY  = 4'hE;
    localparam logic [3:0] OPC_MISC = 4'hF;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] FN_GET_DT = 8'h07;
    localparam logic [7:0] FN_WAITK  = 8'h0A;
    localparam logic [7:0] FN_SET_DT = 8'h15;
    localparam logic [7:0] FN_SET_ST = 8'h18;
    localparam logic [7:0] FN_ADD_I  = 8'h1E;
    localparam logic [7:0] FN_FONT   = 8'h29;
    localparam logic [7:0] FN_BCD    = 8'h33;
    localparam logic [7:0] FN_STORE  = 8'h55;
    localparam logic [7:0] FN_LOAD   = 8'h65;

    localparam logic [3:0] REG_VF = 4'hF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RET,
        S_FLAG,
        S_DRW_MEM,
        S_DRW_ROW,
        S_DRW_B0,
        S_DRW_B1,
        S_BCD,
        S_STORE_RD,
        S_STORE_WR,
        S_LOAD_RD,
        S_LOAD_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [3:0] ra;
        logic [3:0] rb;
        logic       we;
        logic [3:0] wa;
        logic [7:0] wd;
    } t_rf_ctl;

    typedef struct packed {
        logic [DISP_AW-1:0] raddr;
        logic               we;
        logic [DISP_AW-1:0] waddr;
        logic [7:0]         wd;
        logic               clear;
    } t_disp_ctl;

    // hundreds, tens, ones of a byte, one nibble each
    function automatic logic [11:0] c8ie_bcd(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [3:0]  o;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem  = 7'(v - 8'(h) * 8'd100);
        prod = 15'(rem) * 15'd205;
        t    = prod[14:11];
        o    = 4'(rem - 7'(t) * 7'd10);
        return {2'b00, h, t, o};
    endfunction

endpackage

### rtl/c8ie_regfile.sv
module c8ie_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  c8ie_pkg::t_rf_ctl i_ctl,
    output logic [7:0]        o_qa,
    output logic [7:0]        o_qb
);
    import c8ie_pkg::*;

    logic [7:0]  r_mem [16];
    logic [15:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.wa] <= i_ctl.wd;
        end
        o_qa <= r_valid[i_ctl.ra] ? r_mem[i_ctl.ra] : 8'h00;
        o_qb <= r_valid[i_ctl.rb] ? r_mem[i_ctl.rb] : 8'h00;
    end

    // unwritten registers read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_ctl.wa] <= 1'b1;
        end
    end

endmodule

### rtl/c8ie_display.sv
module c8ie_display (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c8ie_pkg::t_disp_ctl i_ctl,
    output logic [7:0]          o_q
);
    import c8ie_pkg::*;

    logic [7:0]            r_mem [DISP_BYTES];
    logic [DISP_BYTES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wd;
        end
        o_q <= r_valid[i_ctl.raddr] ? r_mem[i_ctl.raddr] : 8'h00;
    end

    // a byte without its valid bit is dark; clear drops all of them at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_ctl.waddr] <= 1'b1;
        end
    end

endmodule

### rtl/chip8_instruction_execute.sv
// Steps: most items pass accept, execute and result; return adds a stack read,
//   flag-setting ALU ops and add-to-index add a VF write, BCD adds a write per
//   digit, register block moves add a read and a write per register, and
//   sprites add memory, row and two byte steps per row and a last memory step.
// One item at a time; the next is taken once the result has moved to the output
//   register; a stalled result holds off input only after the next has finished.
// Reset: synchronous active low; registers, timers and display read as zero,
//   pc is 0x200, the random generator seed is 0xACE1. No clearing pass.
module chip8_instruction_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_instruction,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_keys,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_next_pc,
    output logic [7:0]  o_read_data,
    output logic        o_draw_flag,
    output logic        o_key_wait,
    output logic        o_sound_on
);
    import c8ie_pkg::*;

    // ---------------------------------------------------------------------
    // Item and architectural state
    // ---------------------------------------------------------------------
    t_state      r_state, n_state;
    logic [2:0]  r_op, n_op;
    logic [15:0] r_ins, n_ins;
    logic [11:0] r_addr, n_addr;
    logic [7:0]  r_wdata, n_wdata;
    logic [15:0] r_keys, n_keys;

    logic [11:0]     r_pc, n_pc;
    logic [15:0]     r_i, n_i;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [7:0]      r_dt, n_dt;
    logic [7:0]      r_st, n_st;
    logic [15:0]     r_lfsr, n_lfsr;

    // sequencer scratch
    logic [4:0]         r_cnt, n_cnt;
    logic [7:0]         r_vx, n_vx;
    logic [7:0]         r_vy, n_vy;
    logic               r_coll, n_coll;
    logic               r_flag, n_flag;
    logic [15:0]        r_win, n_win;
    logic [DISP_AW-1:0] r_b0, n_b0;

    // result being built
    logic [7:0] r_rd, n_rd;
    logic       r_draw, n_draw;
    logic       r_wait, n_wait;

    // output register
    logic        r_out_valid;
    logic [11:0] r_o_pc;
    logic [7:0]  r_o_rd;
    logic        r_o_draw;
    logic        r_o_wait;
    logic        r_o_sound;

    // storage ports
    t_rf_ctl    rf_ctl;
    logic [7:0] rf_qa, rf_qb;
    t_disp_ctl  disp_ctl;
    logic [7:0] disp_q;

    logic [7:0]        r_pmem [MEM_DEPTH];
    logic [MEM_AW-1:0] mem_addr;
    logic              mem_we;
    logic [7:0]        mem_wd;
    logic [7:0]        r_mem_q;

    logic [11:0]     r_stack [STACK_DEPTH];
    logic [SP_W-1:0] stk_addr;
    logic            stk_we;
    logic [11:0]     r_stk_q;

    // ---------------------------------------------------------------------
    // Instruction fields and decode
    // ---------------------------------------------------------------------
    logic [3:0]  opc, fx, fy, fn;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [11:0] pc_nxt, pc_skip;
    logic [SP_W-1:0] sp_inc, sp_dec;
    logic        slot_free;

    assign opc     = r_ins[15:12];
    assign fx      = r_ins[11:8];
    assign fy      = r_ins[7:4];
    assign fn      = r_ins[3:0];
    assign nn      = r_ins[7:0];
    assign nnn     = r_ins[11:0];
    assign pc_nxt  = r_pc + 12'd2;
    assign pc_skip = r_pc + 12'd4;
    assign sp_inc  = (r_sp == SP_W'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec  = (r_sp == '0) ? SP_W'(STACK_DEPTH - 1) : r_sp - 1'b1;
    assign slot_free = !r_out_valid || i_out_ready;

    // ALU for the 8XY group; the flag goes to VF in the cycle after the result
    logic [7:0] alu_r;
    logic       alu_f;
    logic       alu_has_flag;
    logic [8:0] alu_sum;

    assign alu_sum = {1'b0, rf_qa} + {1'b0, rf_qb};

    always_comb begin
        alu_r        = rf_qa;
        alu_f        = 1'b0;
        alu_has_flag = 1'b1;
        unique case (fn)
            ALU_MOV:  begin alu_r = rf_qb;          alu_has_flag = 1'b0; end
            ALU_OR:   begin alu_r = rf_qa | rf_qb;  alu_has_flag = 1'b0; end
            ALU_AND:  begin alu_r = rf_qa & rf_qb;  alu_has_flag = 1'b0; end
            ALU_XOR:  begin alu_r = rf_qa ^ rf_qb;  alu_has_flag = 1'b0; end
            ALU_ADD:  begin alu_r = alu_sum[7:0];   alu_f = alu_sum[8]; end
            ALU_SUB:  begin alu_r = rf_qa - rf_qb;  alu_f = rf_qa >= rf_qb; end
            ALU_SHR:  begin alu_r = rf_qa >> 1;     alu_f = rf_qa[0]; end
            ALU_SUBN: begin alu_r = rf_qb - rf_qa;  alu_f = rf_qb >= rf_qa; end
            ALU_SHL:  begin alu_r = rf_qa << 1;     alu_f = rf_qa[7]; end
            default:  begin alu_has_flag = 1'b0; end
        endcase
    end

    // highest pressed key wins
    logic [KEY_W-1:0] key_hi;
    always_comb begin
        key_hi = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (r_keys[k]) begin
                key_hi = KEY_W'(k);
            end
        end
    end

    logic [15:0] lfsr_step;
    assign lfsr_step = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};

    logic [16:0] addi_sum;
    assign addi_sum = {1'b0, r_i} + 17'(rf_qa);

    logic [11:0] bcd;
    assign bcd = c8ie_bcd(r_vx);

    // sprite row placement: pixel base wraps at the display size
    logic [4:0]  drw_row;
    logic [10:0] drw_base;
    assign drw_row  = r_vy[4:0] + r_cnt;
    assign drw_base = {drw_row, 6'b0} + 11'(r_vx);

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (r_op == OP_EXEC) begin
                    priority if (r_ins == INS_RET) begin
                        n_state = S_RET;
                    end else if (opc == OPC_ALU && alu_has_flag) begin
                        n_state = S_FLAG;
                    end else if (opc == OPC_DRW) begin
                        n_state = S_DRW_MEM;
                    end else if (opc == OPC_MISC && nn == FN_ADD_I) begin
                        n_state = S_FLAG;
                    end else if (opc == OPC_MISC && nn == FN_BCD) begin
                        n_state = S_BCD;
                    end else if (opc == OPC_MISC && nn == FN_STORE) begin
                        n_state = S_STORE_RD;
                    end else if (opc == OPC_MISC && nn == FN_LOAD) begin
                        n_state = S_LOAD_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RET:      n_state = S_DONE;
            S_FLAG:     n_state = S_DONE;
            S_DRW_MEM:  n_state = (r_cnt[3:0] == fn) ? S_DONE : S_DRW_ROW;
            S_DRW_ROW:  n_state = S_DRW_B0;
            S_DRW_B0:   n_state = S_DRW_B1;
            S_DRW_B1:   n_state = S_DRW_MEM;
            S_BCD:      n_state = (r_cnt == 5'd2) ? S_DONE : S_BCD;
            S_STORE_RD: n_state = S_STORE_WR;
            S_STORE_WR: n_state = (r_cnt[3:0] == fx) ? S_DONE : S_STORE_RD;
            S_LOAD_RD:  n_state = S_LOAD_WR;
            S_LOAD_WR:  n_state = (r_cnt[3:0] == fx) ? S_DONE : S_LOAD_RD;
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath and storage controls per state
    // ---------------------------------------------------------------------
    always_comb begin
        n_op = r_op; n_ins = r_ins; n_addr = r_addr; n_wdata = r_wdata; n_keys = r_keys;
        n_pc = r_pc; n_i = r_i; n_sp = r_sp; n_dt = r_dt; n_st = r_st; n_lfsr = r_lfsr;
        n_cnt = r_cnt; n_vx = r_vx; n_vy = r_vy; n_coll = r_coll; n_flag = r_flag;
        n_win = r_win; n_b0 = r_b0;
        n_rd = r_rd; n_draw = r_draw; n_wait = r_wait;

        rf_ctl.ra = r_cnt[3:0];
        rf_ctl.rb = fy;
        rf_ctl.we = 1'b0;
        rf_ctl.wa = fx;
        rf_ctl.wd = 8'h00;

        disp_ctl.raddr = r_b0;
        disp_ctl.we    = 1'b0;
        disp_ctl.waddr = r_b0;
        disp_ctl.wd    = 8'h00;
        disp_ctl.clear = 1'b0;

        mem_addr = r_i[MEM_AW-1:0] + MEM_AW'(r_cnt);
        mem_we   = 1'b0;
        mem_wd   = 8'h00;

        stk_addr = r_sp;
        stk_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // issue the register, memory and display reads the item may need; data lands in S_EXEC
                rf_ctl.ra = i_instruction[11:8];
                rf_ctl.rb = (i_instruction[15:12] == OPC_JPV0) ? 4'h0 : i_instruction[7:4];
                mem_addr  = i_address[MEM_AW-1:0];
                disp_ctl.raddr = i_address[DISP_AW-1:0];
                if (i_in_valid) begin
                    n_op = i_operation; n_ins = i_instruction; n_addr = i_address;
                    n_wdata = i_write_data; n_keys = i_keys;
                    n_rd = 8'h00; n_draw = 1'b0; n_wait = 1'b0;
                    n_cnt = '0; n_coll = 1'b0;
                end
            end
            S_EXEC: begin
                n_vx = rf_qa;
                n_vy = rf_qb;
                unique case (r_op)
                    OP_EXEC: begin
                        n_pc = pc_nxt;
                        unique case (opc)
                            OPC_SYS: begin
                                if (r_ins == INS_CLS) begin
                                    disp_ctl.clear = 1'b1;
                                    n_draw = 1'b1;
                                end else if (r_ins == INS_RET) begin
                                    n_sp     = sp_dec;
                                    stk_addr = sp_dec;
                                end
                            end
                            OPC_JP:   n_pc = nnn;
                            OPC_CALL: begin
                                stk_we = 1'b1;
                                n_sp   = sp_inc;
                                n_pc   = nnn;
                            end
                            OPC_SEI:  n_pc = (rf_qa == nn) ? pc_skip : pc_nxt;
                            OPC_SNEI: n_pc = (rf_qa != nn) ? pc_skip : pc_nxt;
                            OPC_SE:   n_pc = (rf_qa == rf_qb) ? pc_skip : pc_nxt;
                            OPC_SNE:  n_pc = (rf_qa != rf_qb) ? pc_skip : pc_nxt;
                            OPC_LDI:  begin rf_ctl.we = 1'b1; rf_ctl.wd = nn; end
                            OPC_ADDI: begin rf_ctl.we = 1'b1; rf_ctl.wd = rf_qa + nn; end
                            OPC_ALU: begin
                                if (fn <= ALU_SUBN || fn == ALU_SHL) begin
                                    rf_ctl.we = 1'b1;
                                    rf_ctl.wd = alu_r;
                                end
                                n_flag = alu_f;
                            end
                            OPC_LDIX: n_i = {4'h0, nnn};
                            OPC_JPV0: n_pc = nnn + 12'(rf_qb);
                            OPC_RND: begin
                                n_lfsr    = lfsr_step;
                                rf_ctl.we = 1'b1;
                                rf_ctl.wd = lfsr_step[7:0] & nn;
                            end
                            OPC_DRW: n_draw = 1'b1;
                            OPC_KEY: begin
                                if (nn == KEY_SKP) begin
                                    n_pc = r_keys[rf_qa[3:0]] ? pc_skip : pc_nxt;
                                end else if (nn == KEY_SKNP) begin
                                    n_pc = r_keys[rf_qa[3:0]] ? pc_nxt : pc_skip;
                                end
                            end
                            OPC_MISC: begin
                                unique case (nn)
                                    FN_GET_DT: begin rf_ctl.we = 1'b1; rf_ctl.wd = r_dt; end
                                    FN_WAITK: begin
                                        if (r_keys == 16'h0000) begin
                                            n_wait = 1'b1;
                                            n_pc   = r_pc;
                                        end else begin
                                            rf_ctl.we = 1'b1;
                                            rf_ctl.wd = 8'(key_hi);
                                        end
                                    end
                                    FN_SET_DT: n_dt = rf_qa;
                                    FN_SET_ST: n_st = rf_qa;
                                    FN_ADD_I: begin
                                        n_flag = addi_sum > 17'h00FFF;
                                        n_i    = addi_sum[15:0];
                                    end
                                    FN_FONT: n_i = 16'(FONT_BASE) + 16'(rf_qa[3:0]) * 16'd5;
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                    OP_MEM_WR: begin
                        mem_addr = r_addr[MEM_AW-1:0];
                        mem_we   = 1'b1;
                        mem_wd   = r_wdata;
                    end
                    OP_MEM_RD:  n_rd = r_mem_q;
                    OP_DISP_RD: n_rd = disp_q;
                    OP_TICK: begin
                        if (r_dt != 8'h00) n_dt = r_dt - 8'd1;
                        if (r_st != 8'h00) n_st = r_st - 8'd1;
                    end
                    default: ;
                endcase
            end
            S_RET: n_pc = r_stk_q + 12'd2;
            S_FLAG: begin
                rf_ctl.we = 1'b1;
                rf_ctl.wa = REG_VF;
                rf_ctl.wd = {7'b0, r_flag};
            end
            S_DRW_MEM: begin
                // mem read of the next sprite row goes out at the default address
                if (r_cnt[3:0] == fn) begin
                    rf_ctl.we = 1'b1;
                    rf_ctl.wa = REG_VF;
                    rf_ctl.wd = {7'b0, r_coll};
                end
            end
            S_DRW_ROW: begin
                n_win = {r_mem_q, 8'h00} >> drw_base[2:0];
                n_b0  = drw_base[10:3];
                disp_ctl.raddr = drw_base[10:3];
            end
            S_DRW_B0: begin
                disp_ctl.we    = 1'b1;
                disp_ctl.waddr = r_b0;
                disp_ctl.wd    = disp_q ^ r_win[15:8];
                disp_ctl.raddr = r_b0 + 1'b1;
                n_coll = r_coll | (|(disp_q & r_win[15:8]));
            end
            S_DRW_B1: begin
                disp_ctl.we    = 1'b1;
                disp_ctl.waddr = r_b0 + 1'b1;
                disp_ctl.wd    = disp_q ^ r_win[7:0];
                n_coll = r_coll | (|(disp_q & r_win[7:0]));
                n_cnt  = r_cnt + 5'd1;
            end
            S_BCD: begin
                mem_we = 1'b1;
                unique case (r_cnt[1:0])
                    2'd0:    mem_wd = {4'h0, bcd[11:8]};
                    2'd1:    mem_wd = {4'h0, bcd[7:4]};
                    default: mem_wd = {4'h0, bcd[3:0]};
                endcase
                n_cnt = r_cnt + 5'd1;
            end
            S_STORE_RD: ;
            S_STORE_WR: begin
                mem_we = 1'b1;
                mem_wd = rf_qa;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt[3:0] == fx) begin
                    n_i = r_i + 16'(fx) + 16'd1;
                end
            end
            S_LOAD_RD: ;
            S_LOAD_WR: begin
                rf_ctl.we = 1'b1;
                rf_ctl.wa = r_cnt[3:0];
                rf_ctl.wd = r_mem_q;
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt[3:0] == fx) begin
                    n_i = r_i + 16'(fx) + 16'd1;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= 12'h200;
            r_i     <= 16'h0000;
            r_sp    <= '0;
            r_dt    <= 8'h00;
            r_st    <= 8'h00;
            r_lfsr  <= 16'hACE1;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_sp    <= n_sp;
            r_dt    <= n_dt;
            r_st    <= n_st;
            r_lfsr  <= n_lfsr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_ins <= n_ins; r_addr <= n_addr; r_wdata <= n_wdata; r_keys <= n_keys;
        r_cnt <= n_cnt; r_vx <= n_vx; r_vy <= n_vy; r_coll <= n_coll; r_flag <= n_flag;
        r_win <= n_win; r_b0 <= n_b0;
        r_rd <= n_rd; r_draw <= n_draw; r_wait <= n_wait;
    end

    // output register: load on completion, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && slot_free) begin
            r_o_pc    <= r_pc;
            r_o_rd    <= r_rd;
            r_o_draw  <= r_draw;
            r_o_wait  <= r_wait;
            r_o_sound <= r_st != 8'h00;
        end
    end

    // program memory and return stack, one access each per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pmem[mem_addr] <= mem_wd;
        end
        r_mem_q <= r_pmem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_addr] <= r_pc;
        end
        r_stk_q <= r_stack[stk_addr];
    end

    c8ie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rf_ctl),
        .o_qa    (rf_qa),
        .o_qb    (rf_qb)
    );

    c8ie_display u_display (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (disp_ctl),
        .o_q     (disp_q)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_next_pc   = r_o_pc;
    assign o_read_data = r_o_rd;
    assign o_draw_flag = r_o_draw;
    assign o_key_wait  = r_o_wait;
    assign o_sound_on  = r_o_sound;

endmodule

### rtl/c8ie_checker.sv
module c8ie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [11:0] o_next_pc,
    input logic [7:0]  o_read_data,
    input logic        o_draw_flag,
    input logic        o_key_wait
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_next_pc))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_wait_no_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_wait |-> !o_draw_flag && o_read_data == 8'h00)
        else $error("key wait item also drew or read");

    a_draw_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_draw_flag |-> o_read_data == 8'h00)
        else $error("draw item returned read data");

endmodule

bind chip8_instruction_execute c8ie_checker u_c8ie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_next_pc   (o_next_pc),
    .o_read_data (o_read_data),
    .o_draw_flag (o_draw_flag),
    .o_key_wait  (o_key_wait)
);
